FILE: hw/rtl/sre_pkg.sv
// Package for the simple RISC execute unit: operation codes, sizes and the
// instruction item type. No dependencies.
package sre_pkg;
  localparam int DataDepthDefault = 4096;
  localparam int IoRegCountDefault = 32;
  localparam int PcWidthDefault = 12;
  localparam int RegCount = 16;
  localparam int LastProtected = 2;
  localparam int ReturnIo = 7;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MAC = 5'd2, OP_AND = 5'd3, OP_XOR = 5'd4,
    OP_SLL = 5'd5, OP_SRA = 5'd6, OP_SRL = 5'd7, OP_BEQ = 5'd8, OP_BNE = 5'd9,
    OP_BLT = 5'd10, OP_BGT = 5'd11, OP_BLE = 5'd12, OP_BGE = 5'd13,
    OP_JAL = 5'd14, OP_LW = 5'd15, OP_SW = 5'd16, OP_RETI = 5'd17,
    OP_IN = 5'd18, OP_OUT = 5'd19
  } op_t;

  typedef struct packed {
    logic [4:0] operation;
    logic [3:0] dest_index;
    logic [3:0] src_a_index;
    logic [3:0] src_b_index;
    logic [3:0] src_c_index;
  } instr_t;
endpackage

FILE: hw/rtl/sre_if.sv
// Valid/ready channel interfaces for instructions and results.
// No dependencies.
interface sre_instr_if;
  logic valid;
  logic ready;
  logic [4:0] operation;
  logic [3:0] dest_index;
  logic [3:0] src_a_index;
  logic [3:0] src_b_index;
  logic [3:0] src_c_index;
  modport source (output valid, operation, dest_index, src_a_index, src_b_index,
                  src_c_index, input ready);
  modport sink (input valid, operation, dest_index, src_a_index, src_b_index,
                src_c_index, output ready);
endinterface

interface sre_result_if;
  logic valid;
  logic ready;
  logic [11:0] next_pc;
  logic reg_write;
  logic [31:0] reg_value;
  logic mem_write;
  logic [11:0] mem_address;
  logic [31:0] mem_value;
  logic io_write;
  logic [4:0] io_index;
  modport source (output valid, next_pc, reg_write, reg_value, mem_write, mem_address,
                  mem_value, io_write, io_index, input ready);
  modport sink (input valid, next_pc, reg_write, reg_value, mem_write, mem_address,
                mem_value, io_write, io_index, output ready);
endinterface

FILE: hw/rtl/sre_front.sv
// Front end: accepts instruction items into a two-entry queue.
// Depends on sre_pkg and sre_if.
module sre_front (
  input  logic clk,
  input  logic rst,
  sre_instr_if.sink instr,
  input  logic pop,
  output logic avail,
  output sre_pkg::instr_t head
);
  import sre_pkg::*;
  instr_t q [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic push;

  assign instr.ready = (count != 2'd2);
  assign push = instr.valid && instr.ready;
  assign avail = (count != 2'd0);
  assign head = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{instr.operation, instr.dest_index, instr.src_a_index,
                     instr.src_b_index, instr.src_c_index};
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> avail)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_push_full: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |-> !push) else $error("push into full queue");
endmodule

FILE: hw/rtl/sre_back.sv
// Back end: reads operands, executes, and updates registers, memory, I/O and PC.
// Each instruction does an operand/memory read, then executes and writes back.
// Depends on sre_pkg and sre_if.
module sre_back #(
  parameter int DATA_DEPTH = sre_pkg::DataDepthDefault,
  parameter int IO_REG_COUNT = sre_pkg::IoRegCountDefault,
  parameter int PC_WIDTH = sre_pkg::PcWidthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic avail,
  input  sre_pkg::instr_t head,
  output logic pop,
  sre_result_if.source result
);
  import sre_pkg::*;
  localparam int AW = $clog2(DATA_DEPTH);
  localparam int IW = $clog2(IO_REG_COUNT);

  logic [31:0] regs [RegCount];
  logic [31:0] mem [DATA_DEPTH];
  logic [31:0] io_regs [IO_REG_COUNT];
  logic [PC_WIDTH-1:0] pc;
  logic clearing;
  logic [AW-1:0] clr_addr;

  logic busy;
  instr_t ins;
  logic [31:0] a, b, c, d, mem_rd;

  logic out_free;
  assign out_free = !result.valid || result.ready;
  assign pop = avail && !busy && !clearing;

  logic [31:0] sum;
  logic [AW-1:0] addr;
  assign sum = regs[head.src_a_index] + regs[head.src_b_index];
  assign addr = sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (pop) begin
      ins <= head;
      a <= regs[head.src_a_index];
      b <= regs[head.src_b_index];
      c <= regs[head.src_c_index];
      d <= regs[head.dest_index];
      mem_rd <= mem[addr];
    end
  end

  logic [31:0] s, val, mval, prod, iord;
  logic wr, mw, iw, taken, in_rng;
  logic [PC_WIDTH-1:0] nxt, tgt;
  logic [AW-1:0] eaddr;
  op_t op;

  assign prod = a * b;

  always_comb begin
    op = op_t'(ins.operation);
    s = a + b;
    eaddr = s[AW-1:0];
    in_rng = s < 32'(IO_REG_COUNT);
    iord = in_rng ? io_regs[s[IW-1:0]] : 32'd0;
    nxt = pc + 1'b1;
    tgt = c[PC_WIDTH-1:0];
    wr = 1'b0; mw = 1'b0; iw = 1'b0; taken = 1'b0;
    val = 32'd0; mval = 32'd0;
    case (op)
      OP_ADD: begin wr = 1'b1; val = a + b + c; end
      OP_SUB: begin wr = 1'b1; val = a - b - c; end
      OP_MAC: begin wr = 1'b1; val = prod + c; end
      OP_AND: begin wr = 1'b1; val = a & b & c; end
      OP_XOR: begin wr = 1'b1; val = a ^ b ^ c; end
      OP_SLL: begin wr = 1'b1; val = (b >= 32'd32) ? 32'd0 : a << b[4:0]; end
      OP_SRA: begin
        wr = 1'b1;
        val = (b >= 32'd32) ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]);
      end
      OP_SRL: begin wr = 1'b1; val = (b >= 32'd32) ? 32'd0 : a >> b[4:0]; end
      OP_BEQ: taken = (a == b);
      OP_BNE: taken = (a != b);
      OP_BLT: taken = (a < b);
      OP_BGT: taken = (a > b);
      OP_BLE: taken = (a <= b);
      OP_BGE: taken = (a >= b);
      OP_JAL: begin wr = 1'b1; val = 32'(nxt); taken = 1'b1; end
      OP_LW: begin wr = 1'b1; val = mem_rd + c; end
      OP_SW: begin mw = 1'b1; mval = c + d; end
      OP_RETI: nxt = io_regs[ReturnIo][PC_WIDTH-1:0];
      OP_IN: begin wr = 1'b1; val = iord; end
      OP_OUT: iw = in_rng;
      default: ;
    endcase
    if (taken) nxt = tgt;
    if (!(wr && ins.dest_index > 4'(LastProtected))) begin
      wr = 1'b0;
      val = 32'd0;
    end
  end

  logic fire;
  assign fire = busy && out_free;

  always_ff @(posedge clk) begin
    if (clearing) mem[clr_addr] <= 32'd0;
    else if (fire && mw) mem[eaddr] <= mval;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (wr) regs[ins.dest_index] <= val;
      if (iw) io_regs[s[IW-1:0]] <= c;
      result.next_pc <= 12'(nxt);
      result.reg_write <= wr;
      result.reg_value <= val;
      result.mem_write <= mw;
      result.mem_address <= (op == OP_LW || op == OP_SW) ? 12'(eaddr) : 12'd0;
      result.mem_value <= mval;
      result.io_write <= iw;
      result.io_index <= (op == OP_IN || op == OP_OUT) ? s[4:0] : 5'd0;
    end
    if (rst) begin
      busy <= 1'b0;
      result.valid <= 1'b0;
      pc <= '0;
      clearing <= 1'b1;
      clr_addr <= '0;
      for (int i = 0; i < RegCount; i++) regs[i] <= 32'd0;
      for (int i = 0; i < IO_REG_COUNT; i++) io_regs[i] <= 32'd0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(DATA_DEPTH - 1)) clearing <= 1'b0;
      end
      if (fire) pc <= nxt;
      if (pop) busy <= 1'b1;
      else if (fire) busy <= 1'b0;
      if (fire) result.valid <= 1'b1;
      else if (result.ready) result.valid <= 1'b0;
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst) pop |-> !busy)
    else $error("pop while busy");
  a_fire_frees: assert property (@(posedge clk) disable iff (rst) fire |=> result.valid)
    else $error("result lost");
  a_protect: assert property (@(posedge clk) disable iff (rst)
    (fire && ins.dest_index <= 4'(LastProtected)) |-> !wr) else $error("protected write");
endmodule

FILE: hw/rtl/simple_risc_execute_unit_core.sv
// Simple RISC execute unit: one decoded instruction item in, one result item out.
// Channel instr (sink) carries operation and four register indices; channel
// result (source) carries next PC and the register, memory and I/O writes.
// A two-entry instruction queue decouples acceptance from execution.
// In the back end each instruction first reads register operands and the
// synchronous data memory port, then executes, writes back and loads the
// result register. A new instruction enters the back end only after the
// previous one has loaded the result register.
// The result register holds its item while the receiver stalls; the back end
// then waits and the queue keeps accepting until it holds two items.
// Synchronous reset clears the registers, I/O bank, PC and queue. After reset
// the data memory is cleared one word per cycle, all DATA_DEPTH words (4096 by
// default), before the first instruction executes; the queue still accepts.
// Depends on sre_pkg, sre_if, sre_front and sre_back.
module simple_risc_execute_unit_core #(
  parameter int DATA_DEPTH = sre_pkg::DataDepthDefault,
  parameter int IO_REG_COUNT = sre_pkg::IoRegCountDefault,
  parameter int PC_WIDTH = sre_pkg::PcWidthDefault
) (
  input logic clk,
  input logic rst,
  sre_instr_if.sink instr,
  sre_result_if.source result
);
  import sre_pkg::*;
  logic pop, avail;
  instr_t head;

  sre_front u_front (.clk, .rst, .instr, .pop, .avail, .head);
  sre_back #(.DATA_DEPTH(DATA_DEPTH), .IO_REG_COUNT(IO_REG_COUNT), .PC_WIDTH(PC_WIDTH))
    u_back (.clk, .rst, .avail, .head, .pop, .result);
endmodule

FILE: tb/simple_risc_execute_unit_core_tb.sv
// Testbench for the simple RISC execute unit: drives instruction items, partly with
// random gaps, predicts each result item and compares it whole at the result channel.
// Depends on sre_pkg, sre_if and the simple_risc_execute_unit_core RTL.
`timescale 1ns / 100ps

module simple_risc_execute_unit_core_tb;
  import sre_pkg::*;

  localparam int DataDepth = 4096;
  localparam int IoRegCount = 32;
  localparam int RandomItems = 1100;
  localparam int StallLimit = 20000;

  typedef struct packed {
    logic [11:0] next_pc;
    logic reg_write;
    logic [31:0] reg_value;
    logic mem_write;
    logic [11:0] mem_address;
    logic [31:0] mem_value;
    logic io_write;
    logic [4:0] io_index;
  } outcome_t;

  class exec_scoreboard;
    logic [31:0] regs [RegCount];
    logic [31:0] dmem [DataDepth];
    logic [31:0] ports [IoRegCount];
    logic [11:0] pc;
    outcome_t pending [$];
    int mismatches;

    function void clear();
      foreach (regs[i]) regs[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      foreach (ports[i]) ports[i] = '0;
      pc = '0;
      pending.delete();
      mismatches = 0;
    endfunction

    function logic [31:0] shift_right_signed(logic [31:0] x, logic [31:0] amt);
      if (amt >= 32) return {32{x[31]}};
      return $unsigned($signed(x) >>> amt[4:0]);
    endfunction

    function void note_instr(instr_t it);
      outcome_t r;
      logic [31:0] a, b, c, d, sum, val;
      logic [11:0] nxt, addr;
      logic wr, taken;
      a = regs[it.src_a_index];
      b = regs[it.src_b_index];
      c = regs[it.src_c_index];
      d = regs[it.dest_index];
      sum = a + b;
      addr = sum[11:0];
      nxt = pc + 12'd1;
      wr = 1'b0;
      taken = 1'b0;
      val = '0;
      r = '0;
      case (it.operation)
        OP_ADD: begin wr = 1; val = a + b + c; end
        OP_SUB: begin wr = 1; val = a - b - c; end
        OP_MAC: begin wr = 1; val = a * b + c; end
        OP_AND: begin wr = 1; val = a & b & c; end
        OP_XOR: begin wr = 1; val = a ^ b ^ c; end
        OP_SLL: begin wr = 1; val = (b >= 32) ? '0 : a << b[4:0]; end
        OP_SRA: begin wr = 1; val = shift_right_signed(a, b); end
        OP_SRL: begin wr = 1; val = (b >= 32) ? '0 : a >> b[4:0]; end
        OP_BEQ: taken = (a == b);
        OP_BNE: taken = (a != b);
        OP_BLT: taken = (a < b);
        OP_BGT: taken = (a > b);
        OP_BLE: taken = (a <= b);
        OP_BGE: taken = (a >= b);
        OP_JAL: begin wr = 1; val = {20'd0, nxt}; taken = 1; end
        OP_LW: begin
          wr = 1; r.mem_address = addr; val = dmem[addr] + c;
        end
        OP_SW: begin
          r.mem_write = 1; r.mem_address = addr; r.mem_value = c + d;
          dmem[addr] = c + d;
        end
        OP_RETI: nxt = ports[ReturnIo][11:0];
        OP_IN: begin
          wr = 1; r.io_index = sum[4:0];
          val = (sum < IoRegCount) ? ports[sum[4:0]] : '0;
        end
        OP_OUT: begin
          r.io_index = sum[4:0];
          if (sum < IoRegCount) begin
            ports[sum[4:0]] = c;
            r.io_write = 1;
          end
        end
        default: ;
      endcase
      if (taken) nxt = c[11:0];
      if (wr && it.dest_index > LastProtected) begin
        regs[it.dest_index] = val;
        r.reg_write = 1;
        r.reg_value = val;
      end
      pc = nxt;
      r.next_pc = nxt;
      pending.push_back(r);
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("Mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  sre_instr_if instr ();
  sre_result_if result ();
  exec_scoreboard board;
  int idle_cycles;
  bit sending_done;

  simple_risc_execute_unit_core DUT (
    .clk(clk),
    .rst(rst),
    .instr(instr.sink),
    .result(result.sink)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    instr.valid = 1'b0;
    instr.operation = '0;
    instr.dest_index = '0;
    instr.src_a_index = '0;
    instr.src_b_index = '0;
    instr.src_c_index = '0;
    result.ready = 1'b0;
  end

  function automatic logic [3:0] pick_reg(bit low_heavy);
    if (low_heavy && $urandom_range(0, 3) == 0) return 4'($urandom_range(0, 2));
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic send_instr(op_t op, logic [3:0] rd, logic [3:0] rs, logic [3:0] rt,
                            logic [3:0] rm, bit with_gap);
    int gap;
    gap = with_gap ? $urandom_range(0, 14) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      instr.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr.valid <= 1'b1;
    instr.operation <= op;
    instr.dest_index <= rd;
    instr.src_a_index <= rs;
    instr.src_b_index <= rt;
    instr.src_c_index <= rm;
    do @(posedge clk); while (!instr.ready);
    board.note_instr({op, rd, rs, rt, rm});
  endtask

  task automatic send_random(bit with_gap);
    op_t op;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) op = op_t'($urandom_range(0, 4));
    else if (sel < 50) op = op_t'($urandom_range(5, 7));
    else if (sel < 68) op = op_t'($urandom_range(8, 14));
    else if (sel < 82) op = op_t'($urandom_range(15, 16));
    else op = op_t'($urandom_range(17, 19));
    send_instr(op, pick_reg(1), pick_reg(1), pick_reg(1), pick_reg(1), with_gap);
  endtask

  initial begin
    board = new();
    board.clear();
    sending_done = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed part: a fixed sequence over all operations but BNE, BGT and BLE.
    send_instr(OP_SUB, 4'd3, 4'd0, 4'd0, 4'd0, 0);
    send_instr(OP_SLL, 4'd4, 4'd0, 4'd0, 4'd0, 0);
    send_instr(OP_SUB, 4'd5, 4'd0, 4'd3, 4'd0, 0);
    send_instr(OP_ADD, 4'd6, 4'd5, 4'd5, 4'd5, 0);
    send_instr(OP_SRL, 4'd7, 4'd3, 4'd5, 4'd0, 0);
    send_instr(OP_ADD, 4'd1, 4'd5, 4'd5, 4'd0, 0);
    send_instr(OP_SRA, 4'd8, 4'd3, 4'd6, 4'd0, 0);
    send_instr(OP_SRL, 4'd8, 4'd3, 4'd3, 4'd0, 0);
    send_instr(OP_SLL, 4'd9, 4'd3, 4'd3, 4'd0, 0);
    send_instr(OP_SRA, 4'd10, 4'd7, 4'd3, 4'd0, 0);
    send_instr(OP_MAC, 4'd11, 4'd3, 4'd3, 4'd3, 0);
    send_instr(OP_AND, 4'd12, 4'd3, 4'd3, 4'd5, 0);
    send_instr(OP_XOR, 4'd13, 4'd3, 4'd5, 4'd7, 0);
    send_instr(OP_SW, 4'd3, 4'd3, 4'd3, 4'd3, 0);
    send_instr(OP_LW, 4'd14, 4'd3, 4'd3, 4'd5, 0);
    send_instr(OP_OUT, 4'd0, 4'd6, 4'd6, 4'd3, 0);
    send_instr(OP_OUT, 4'd0, 4'd3, 4'd5, 4'd7, 0);
    send_instr(OP_IN, 4'd15, 4'd6, 4'd6, 4'd0, 0);
    send_instr(OP_IN, 4'd15, 4'd3, 4'd3, 4'd0, 0);
    send_instr(OP_BGE, 4'd0, 4'd5, 4'd5, 4'd3, 0);
    send_instr(OP_BLT, 4'd0, 4'd5, 4'd3, 4'd7, 0);
    send_instr(OP_BEQ, 4'd0, 4'd0, 4'd0, 4'd6, 0);
    send_instr(OP_JAL, 4'd9, 4'd0, 4'd0, 4'd9, 0);
    send_instr(OP_JAL, 4'd2, 4'd0, 4'd0, 4'd3, 0);
    send_instr(OP_RETI, 4'd0, 4'd0, 4'd0, 4'd0, 0);
    for (int i = 0; i < RandomItems; i++) begin
      if ($urandom_range(0, 9) == 0) send_instr(op_t'($urandom_range(8, 13)),
                                                pick_reg(0), pick_reg(0), pick_reg(0),
                                                pick_reg(0), 1);
      else send_random(i < 300 || i > 600);
    end
    instr.valid <= 1'b0;
    sending_done = 1;
  end

  initial begin
    bit gaps;
    int wait_cycles;
    result.ready <= 1'b0;
    @(negedge rst);
    do @(posedge clk); while (!result.valid);
    result.ready <= 1'b1;
    repeat (60) @(posedge clk);
    result.ready <= 1'b0;
    repeat (150) @(posedge clk);
    forever begin
      gaps = ($urandom_range(0, 4) != 0);
      repeat ($urandom_range(20, 80)) begin
        wait_cycles = gaps ? $urandom_range(0, 14) : 0;
        if (wait_cycles > 0) begin
          result.ready <= 1'b0;
          repeat (wait_cycles) @(posedge clk);
        end
        result.ready <= 1'b1;
        do @(posedge clk); while (!result.valid);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready)
      board.check_result({result.next_pc, result.reg_write, result.reg_value,
                          result.mem_write, result.mem_address, result.mem_value,
                          result.io_write, result.io_index});
  end

  always @(posedge clk) begin
    if (rst || (instr.valid && instr.ready) || (result.valid && result.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    wait (sending_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    wait (idle_cycles >= StallLimit);
    $display("Verification failed");
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/sre_pkg.sv
hw/rtl/sre_if.sv
hw/rtl/sre_front.sv
hw/rtl/sre_back.sv
hw/rtl/simple_risc_execute_unit_core.sv
tb/simple_risc_execute_unit_core_tb.sv
